>>> rtl/perspective_texture_span_walker_core_macros.svh
// assertion helpers
`ifndef PERSPECTIVE_TEXTURE_SPAN_WALKER_CORE_MACROS_SVH
`define PERSPECTIVE_TEXTURE_SPAN_WALKER_CORE_MACROS_SVH
// implication checked every edge outside reset
`define PTSW_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define PTSW_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> rtl/ptsw_pkg.sv
package ptsw_pkg;
	localparam int unsigned TILE_WIDTH_DEF = 64;
	localparam int unsigned FX_W = 24;
	localparam int unsigned TEX_W = 10;
	localparam int unsigned ROW_W = 6;
	localparam int unsigned QDEPTH = 2;
	localparam logic [0:0] REG_TEX_W = 1'b0;
	localparam logic [0:0] REG_TEX_H = 1'b1;
	localparam logic signed [FX_W-1:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [FX_W-1:0] S24_MIN = -24'sh800000;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [7:0] xs;
		logic [7:0] xe;
		logic signed [FX_W-1:0] u;
		logic signed [FX_W-1:0] v;
		logic signed [FX_W-1:0] w;
		logic signed [FX_W-1:0] su;
		logic signed [FX_W-1:0] sv;
		logic signed [FX_W-1:0] sw;
	} span_t;

	typedef struct packed {
		logic [ROW_W-1:0] pixel_x;
		logic [ROW_W-1:0] pixel_y;
		logic [TEX_W-1:0] texel_x;
		logic [TEX_W-1:0] texel_y;
		logic last_pixel;
	} pix_t;

	typedef struct packed {
		logic signed [FX_W-1:0] left_x;
		logic signed [FX_W-1:0] right_x;
		logic signed [FX_W-1:0] left_u;
		logic signed [FX_W-1:0] right_u;
		logic signed [FX_W-1:0] left_v;
		logic signed [FX_W-1:0] right_v;
		logic signed [FX_W-1:0] left_w;
		logic signed [FX_W-1:0] right_w;
		logic signed [FX_W-1:0] step_u;
		logic signed [FX_W-1:0] step_v;
		logic signed [FX_W-1:0] step_w;
		logic [ROW_W-1:0] row;
	} req_t;

	typedef enum logic [2:0] {
		F_IDLE, F_DIV, F_MUL, F_ADD, F_PUSH
	} fstate_t;

	typedef enum logic [1:0] {
		B_IDLE, B_DIV, B_OUT
	} bstate_t;

	function automatic logic signed [FX_W-1:0] sat24(input logic signed [49:0] a);
		if (a > 50'sd8388607) return S24_MAX;
		else if (a < -50'sd8388608) return S24_MIN;
		else return a[FX_W-1:0];
	endfunction
endpackage

>>> rtl/ptsw_if.sv
interface ptsw_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ptsw_div.sv
// Restoring divider, one quotient bit per cycle; unsigned magnitudes.
module ptsw_div #(parameter int unsigned W = 48) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] num,
	input logic [W-1:0] den,
	output logic busy,
	output logic [W-1:0] quo
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign busy = (cnt_q != '0);
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/ptsw_front.sv
// Span setup: clip, slopes by division, pre-step of the start values.
module ptsw_front #(parameter int unsigned TILE_WIDTH = ptsw_pkg::TILE_WIDTH_DEF) (
	input logic clk,
	input logic arst_n,
	ptsw_if.sink in_ch,
	ptsw_if.source sp_ch
);
	localparam int unsigned FX = ptsw_pkg::FX_W;
	ptsw_pkg::req_t r_q;
	ptsw_pkg::fstate_t st_q, st_d;
	ptsw_pkg::span_t sp_q;
	logic [1:0] k_q;
	logic signed [FX-1:0] d_q [3];
	logic signed [49:0] prod_q;
	logic [FX:0] dist_q;
	logic signed [FX+1:0] pre_q;
	logic [47:0] num_mag, quo;
	logic num_neg_q, div_busy, div_start, div_go_q;
	logic k_q_done_q;
	logic signed [FX:0] diff;
	logic signed [9:0] xs_c, xe_c, xs_k, xe_k;

	// ceil of S7.16, then tile clip
	assign xs_c = 10'(($signed({r_q.left_x[FX-1], r_q.left_x}) + 25'sd65535) >>> 16);
	assign xe_c = 10'(($signed({r_q.right_x[FX-1], r_q.right_x}) + 25'sd65535) >>> 16);
	assign xs_k = (xs_c < 0) ? 10'sd0 : xs_c;
	assign xe_k = (xe_c > $signed(10'(TILE_WIDTH))) ? $signed(10'(TILE_WIDTH)) : xe_c;

	always_comb begin
		case (k_q)
			2'd0: diff = r_q.right_u - r_q.left_u;
			2'd1: diff = r_q.right_v - r_q.left_v;
			default: diff = r_q.right_w - r_q.left_w;
		endcase
		num_mag = diff[FX] ? 48'(-diff) << 16 : 48'(diff) << 16;
	end

	ptsw_div #(.W(48)) u_div (.clk, .arst_n, .start(div_start), .num(num_mag),
		.den(48'(dist_q)), .busy(div_busy), .quo(quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ptsw_pkg::F_IDLE;
			div_go_q <= 1'b0;
		end else begin
			st_q <= st_d;
			div_go_q <= div_start;
		end
	end

	always_comb begin
		st_d = st_q;
		in_ch.ready = 1'b0;
		sp_ch.valid = 1'b0;
		div_start = 1'b0;
		unique case (st_q)
			ptsw_pkg::F_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) st_d = ptsw_pkg::F_DIV;
			end
			ptsw_pkg::F_DIV: begin
				if (xs_k >= xe_k) st_d = ptsw_pkg::F_IDLE;
				else if (!div_busy && !div_go_q) begin
					if (k_q == 2'd3) st_d = ptsw_pkg::F_MUL;
					else if (!k_q_done_q) div_start = 1'b1;
				end
			end
			ptsw_pkg::F_MUL: st_d = ptsw_pkg::F_ADD;
			ptsw_pkg::F_ADD: if (k_q == 2'd2) st_d = ptsw_pkg::F_PUSH;
				else st_d = ptsw_pkg::F_MUL;
			ptsw_pkg::F_PUSH: begin
				sp_ch.valid = 1'b1;
				if (sp_ch.ready) st_d = ptsw_pkg::F_IDLE;
			end
			default: st_d = ptsw_pkg::F_IDLE;
		endcase
	end

	assign sp_ch.data = sp_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			ptsw_pkg::F_IDLE: begin
				r_q <= in_ch.data;
				k_q <= 2'd0;
				dist_q <= in_ch.data.right_x - in_ch.data.left_x;
			end
			ptsw_pkg::F_DIV: begin
				pre_q <= $signed({xs_k[7:0], 16'd0}) - r_q.left_x;
				sp_q.xs <= xs_k[7:0];
				sp_q.xe <= xe_k[7:0];
				sp_q.row <= r_q.row;
				sp_q.su <= r_q.step_u;
				sp_q.sv <= r_q.step_v;
				sp_q.sw <= r_q.step_w;
				if (div_start) num_neg_q <= diff[FX];
				// collect a finished quotient, or rewind the index for the pre-step
				if (!div_busy && !div_go_q) begin
					if (k_q == 2'd3) k_q <= 2'd0;
					else if (k_q_done_q) begin
						d_q[k_q] <= ptsw_pkg::sat24(num_neg_q ? -$signed({2'b0, quo}) :
							$signed({2'b0, quo}));
						k_q <= k_q + 2'd1;
					end
				end
			end
			ptsw_pkg::F_MUL: prod_q <= 50'(d_q[k_q] * pre_q);
			ptsw_pkg::F_ADD: begin
				case (k_q)
					2'd0: sp_q.u <= ptsw_pkg::sat24(50'(r_q.left_u) +
						((prod_q < 0) ? -((-prod_q) >>> 16) : (prod_q >>> 16)));
					2'd1: sp_q.v <= ptsw_pkg::sat24(50'(r_q.left_v) +
						((prod_q < 0) ? -((-prod_q) >>> 16) : (prod_q >>> 16)));
					default: sp_q.w <= ptsw_pkg::sat24(50'(r_q.left_w) +
						((prod_q < 0) ? -((-prod_q) >>> 16) : (prod_q >>> 16)));
				endcase
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	// marks that a division for the current index ran
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q_done_q <= 1'b0;
		else if (div_start) k_q_done_q <= 1'b1;
		else if (st_q == ptsw_pkg::F_DIV && !div_busy && !div_go_q)
			k_q_done_q <= 1'b0;
	end
endmodule

>>> rtl/ptsw_back.sv
// Pixel loop: per-pixel divide by w, texel rounding, accumulate.
module ptsw_back (
	input logic clk,
	input logic arst_n,
	input logic [ptsw_pkg::TEX_W-1:0] tex_w,
	input logic [ptsw_pkg::TEX_W-1:0] tex_h,
	ptsw_if.sink sp_ch,
	ptsw_if.source px_ch
);
	localparam int unsigned FX = ptsw_pkg::FX_W;
	localparam int unsigned TEX_W_L = ptsw_pkg::TEX_W;
	ptsw_pkg::bstate_t st_q, st_d;
	ptsw_pkg::span_t s_q;
	logic [7:0] x_q;
	logic k_q, done_q, neg_q, go_q, start;
	logic [47:0] num, den, quo;
	logic busy;
	logic nm;
	logic [TEX_W_L-1:0] tx_q, ty_q;
	logic [TEX_W_L-1:0] scale, tsat;
	logic signed [FX-1:0] nsel;
	ptsw_pkg::pix_t o_q;
	logic ov_q;
	logic load, last;

	assign scale = k_q ? tex_h : tex_w;
	assign nsel = k_q ? s_q.v : s_q.u;
	// (2*n*s + w)/(2*w) with signs folded: sign of numerator and of w
	always_comb begin
		logic signed [34:0] ns;
		logic signed [47:0] n2, d2;
		ns = nsel * $signed({1'b0, scale});
		n2 = $signed({{12{ns[34]}}, ns, 1'b0}) + 48'(s_q.w);
		d2 = $signed({{23{s_q.w[FX-1]}}, s_q.w, 1'b0});
		num = n2[47] ? 48'(-n2) : 48'(n2);
		den = d2[47] ? 48'(-d2) : 48'(d2);
		nm = n2[47] ^ d2[47];
	end
	ptsw_div #(.W(48)) u_div (.clk, .arst_n, .start, .num, .den, .busy, .quo);

	always_comb begin
		if (s_q.w == '0) tsat = (nsel > 0) ? scale : '0;
		else if (neg_q) tsat = '0;
		else if (quo > 48'(scale)) tsat = scale;
		else tsat = quo[TEX_W_L-1:0];
	end

	// output register takes a pixel when empty or being emptied
	assign load = (st_q == ptsw_pkg::B_OUT) && (!ov_q || px_ch.ready);
	assign last = (x_q + 8'd1 == s_q.xe);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ptsw_pkg::B_IDLE;
			ov_q <= 1'b0;
			go_q <= 1'b0;
		end else begin
			st_q <= st_d;
			go_q <= start;
			if (load) ov_q <= 1'b1;
			else if (px_ch.ready) ov_q <= 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		sp_ch.ready = 1'b0;
		start = 1'b0;
		unique case (st_q)
			ptsw_pkg::B_IDLE: begin
				sp_ch.ready = 1'b1;
				if (sp_ch.valid) st_d = ptsw_pkg::B_DIV;
			end
			ptsw_pkg::B_DIV: if (!busy && !go_q) begin
				if (done_q && k_q) st_d = ptsw_pkg::B_OUT;
				else if (!done_q) start = 1'b1;
			end
			ptsw_pkg::B_OUT: if (load) st_d = last ? ptsw_pkg::B_IDLE : ptsw_pkg::B_DIV;
			default: st_d = ptsw_pkg::B_IDLE;
		endcase
	end

	assign px_ch.valid = ov_q;
	assign px_ch.data = o_q;

	always_ff @(posedge clk) begin
		if (st_q == ptsw_pkg::B_IDLE) begin
			s_q <= sp_ch.data;
			x_q <= sp_ch.data.xs;
			k_q <= 1'b0;
			done_q <= 1'b0;
		end
		if (start) begin
			neg_q <= nm;
			done_q <= 1'b1;
		end
		if (st_q == ptsw_pkg::B_DIV && !busy && !go_q && done_q) begin
			done_q <= 1'b0;
			if (!k_q) begin
				tx_q <= tsat;
				k_q <= 1'b1;
			end else begin
				ty_q <= tsat;
			end
		end
		if (load) begin
			o_q.pixel_x <= x_q[5:0];
			o_q.pixel_y <= s_q.row;
			o_q.texel_x <= tx_q;
			o_q.texel_y <= ty_q;
			o_q.last_pixel <= last;
			k_q <= 1'b0;
			x_q <= x_q + 8'd1;
			s_q.u <= ptsw_pkg::sat24(50'(s_q.u) + 50'(s_q.su));
			s_q.v <= ptsw_pkg::sat24(50'(s_q.v) + 50'(s_q.sv));
			s_q.w <= ptsw_pkg::sat24(50'(s_q.w) + 50'(s_q.sw));
		end
	end
endmodule

>>> rtl/ptsw_queue.sv
// Two-entry span queue between setup and pixel loop.
module ptsw_queue (
	input logic clk,
	input logic arst_n,
	ptsw_if.sink i_ch,
	ptsw_if.source o_ch
);
	ptsw_pkg::span_t m_q [ptsw_pkg::QDEPTH];
	logic [0:0] wp_q, rp_q;
	logic [1:0] n_q;
	logic wr, rd;
	assign i_ch.ready = (n_q != 2'd2);
	assign o_ch.valid = (n_q != 2'd0);
	assign o_ch.data = m_q[rp_q];
	assign wr = i_ch.valid && i_ch.ready;
	assign rd = o_ch.valid && o_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			n_q <= n_q + 2'(wr) - 2'(rd);
		end
	end
	always_ff @(posedge clk) if (wr) m_q[wp_q] <= i_ch.data;
endmodule

>>> rtl/perspective_texture_span_walker_core.sv
// Span walker: a setup unit clips the span to the tile and computes three slopes, one after
// another, with a 48-bit serial divider; an empty span sends setup back to idle before any
// division. A pixel loop then emits the pixels of a span one at a time, with two serial
// divisions by inverse depth per pixel, so a full 64-pixel span needs 128 divisions. A
// two-entry queue lets setup of the next span overlap the pixel loop, and a pixel waits in
// one output register while the receiver stalls. Empty spans give no output.
`include "perspective_texture_span_walker_core_macros.svh"
module perspective_texture_span_walker_core #(
	parameter int unsigned TILE_WIDTH = ptsw_pkg::TILE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [ptsw_pkg::TEX_W-1:0] cfg_data,
	ptsw_if.sink in_ch,
	ptsw_if.source out_ch
);
	logic [ptsw_pkg::TEX_W-1:0] tw_q, th_q;
	ptsw_if #(.T(ptsw_pkg::span_t)) f2q ();
	ptsw_if #(.T(ptsw_pkg::span_t)) q2b ();

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= 10'd31;
			th_q <= 10'd31;
		end else if (cfg_we) begin
			if (cfg_index == ptsw_pkg::REG_TEX_W) tw_q <= cfg_data;
			else th_q <= cfg_data;
		end
	end

	ptsw_front #(.TILE_WIDTH(TILE_WIDTH)) u_front (.clk, .arst_n, .in_ch, .sp_ch(f2q));
	ptsw_queue u_queue (.clk, .arst_n, .i_ch(f2q), .o_ch(q2b));
	ptsw_back u_back (.clk, .arst_n, .tex_w(tw_q), .tex_h(th_q), .sp_ch(q2b),
		.px_ch(out_ch));

	`PTSW_ASSERT_IMP(a_tex_x, clk, arst_n, out_ch.valid, out_ch.data.texel_x <= tw_q)
	`PTSW_ASSERT_NXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
